### sv/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg: shared types and constants for Bezier degree elevation
// Holds payload widths, the divider length and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package bde_pkg;

	localparam int VAL_W     = 32;  // Q16.16 coordinate
	localparam int K_W       = 9;   // row length 1..256
	localparam int POS_W     = 8;   // index within a row
	localparam int SUM_W     = 42;  // signed weighted sum
	localparam int MAG_W     = 40;  // magnitude of the weighted sum
	localparam int DIV_STEPS = 40;  // one quotient bit per step
	localparam int CNT_W     = 6;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic       REG_ROW_POINTS   = 1'b0;  // register index
	localparam logic [K_W-1:0] ROW_POINTS_RESET = 9'd2;

	typedef struct packed {
		logic accept;     // latch operands, advance row state
		logic mul;        // form both weighted products
		logic sum;        // add the products
		logic div_init;   // load magnitude and sign into the divider
		logic div_step;   // one restoring step
		logic emit_q;     // load Q(i) into the output register
		logic emit_end;   // load Q(k) with row_end set
	} bde_cmd_t;

	typedef struct packed {
		logic pos_zero;   // incoming request starts a row
		logic row_last;   // latched request closes its row
		logic div_last;   // final divider step this cycle
		logic out_free;   // output register can take a result
	} bde_sts_t;

endpackage

### sv/bezier_degree_elevation_core.sv
// ----------------------------------------------------------------------------
// bezier_degree_elevation_core: raise a Bezier control row by one degree
// Streams k control coordinates in, returns k+1 raised coordinates.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+----------------------
//   point    | in        | point_valid / point_ready  | point_value
//   raised   | out       | raised_valid / raised_ready| raised_value, row_end
//   config   | in        | APB psel / penable         | row_points @ 0x0
//
// An interior point goes from request to result through accept, multiply,
// add, divider load, 40 restoring-divider steps and one output load, the
// serial divider by k being the long part. A point at row start goes from
// accept straight to its output load. The row's final point adds one more
// result (Q(k)), loaded after Q(i) once the output register is free. Reset
// clears the row position, the previous value and row_points to 2. A stalled
// output holds the core in its emit state; the next request is taken as soon
// as the last result of the current one sits in the output register.
// ----------------------------------------------------------------------------
module bezier_degree_elevation_core import bde_pkg::*; #(
	parameter int MAX_POINTS = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	// input points
	input  logic                    point_valid,
	output logic                    point_ready,
	input  logic signed [VAL_W-1:0] point_value,
	// raised points
	output logic                    raised_valid,
	input  logic                    raised_ready,
	output logic signed [VAL_W-1:0] raised_value,
	output logic                    row_end
);

	logic [K_W-1:0] row_points_q;
	logic           reg_hit;
	bde_cmd_t       cmd;
	bde_sts_t       sts;

	// Register decode: one word, index taken from the word address bit.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == REG_ROW_POINTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_points_q <= ROW_POINTS_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			row_points_q <= pwdata[K_W-1:0];
		end
	end

	// Return the stored length; unmapped words read as zero.
	assign prdata = reg_hit ? {{(DATA_W-K_W){1'b0}}, row_points_q} : '0;

	// Sequencer: one request at a time through the datapath.
	bde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (point_valid),
		.req_ready (point_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Row state, weighted sum, divider and output register.
	bde_dpath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_points   (row_points_q),
		.point_value  (point_value),
		.cmd          (cmd),
		.sts          (sts),
		.raised_valid (raised_valid),
		.raised_ready (raised_ready),
		.raised_value (raised_value),
		.row_end      (row_end)
	);

endmodule

### sv/bde_ctrl.sv
// ----------------------------------------------------------------------------
// bde_ctrl: sequencing state machine
// Walks one request through multiply, add, divide and result emission.
// ----------------------------------------------------------------------------
module bde_ctrl import bde_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  bde_sts_t sts,
	output bde_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MUL   = 7'b0000010,
		ST_SUM   = 7'b0000100,
		ST_DINIT = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_EMIT1 = 7'b0100000,
		ST_EMIT2 = 7'b1000000
	} bde_state_t;

	bde_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = sts.pos_zero ? ST_EMIT1 : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_DINIT;
			end
			ST_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_EMIT1;
				end
			end
			ST_EMIT1: begin
				if (sts.out_free) begin
					cmd.emit_q = 1'b1;
					state_d    = sts.row_last ? ST_EMIT2 : ST_IDLE;
				end
			end
			ST_EMIT2: begin
				if (sts.out_free) begin
					cmd.emit_end = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### sv/bde_dpath.sv
// ----------------------------------------------------------------------------
// bde_dpath: row state, weighted sum, serial divider, output register
// Restoring divider produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bde_dpath import bde_pkg::*; #(
	parameter int MAX_POINTS = 256
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [K_W-1:0]          row_points,
	input  logic signed [VAL_W-1:0] point_value,
	input  bde_cmd_t                cmd,
	output bde_sts_t                sts,
	output logic                    raised_valid,
	input  logic                    raised_ready,
	output logic signed [VAL_W-1:0] raised_value,
	output logic                    row_end
);

	localparam int KCAP = (MAX_POINTS < 256) ? MAX_POINTS : 256;

	logic [K_W-1:0]   k_cfg, k_eff;
	logic [POS_W-1:0] pos_eff, pos_next;
	logic             pos_last;

	logic [POS_W-1:0]        row_pos_q;
	logic signed [VAL_W-1:0] prev_val_q;

	logic signed [VAL_W-1:0] cur_q, prev_op_q;
	logic [K_W-1:0]          pos_op_q, rest_op_q, k_q;
	logic                    pos_zero_q, last_q;

	logic signed [SUM_W-1:0] prod_a_q, prod_b_q, sum_q, sum_neg;
	logic [MAG_W-1:0]        dvd_q;
	logic [K_W-1:0]          rem_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    neg_q;
	logic [K_W:0]            trial;
	logic                    ge;

	logic [VAL_W-1:0]        quot, q_val;
	logic                    out_free;

	// Effective length: zero reads as one, clamp to the supported maximum.
	always_comb begin
		k_cfg = (row_points == '0) ? K_W'(1) : row_points;
		k_eff = (k_cfg > K_W'(KCAP)) ? K_W'(KCAP) : k_cfg;
	end

	always_comb begin
		pos_eff  = ({1'b0, row_pos_q} >= k_eff) ? '0 : row_pos_q;
		pos_last = ({1'b0, pos_eff} + K_W'(1)) >= k_eff;
		pos_next = pos_last ? '0 : pos_eff + POS_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q  <= '0;
			prev_val_q <= '0;
		end else if (cmd.accept) begin
			row_pos_q  <= pos_next;
			prev_val_q <= point_value;
		end
	end

	// Operand capture and arithmetic.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_q      <= point_value;
			prev_op_q  <= prev_val_q;
			pos_op_q   <= {1'b0, pos_eff};
			rest_op_q  <= k_eff - {1'b0, pos_eff};
			k_q        <= k_eff;
			pos_zero_q <= (pos_eff == '0);
			last_q     <= pos_last;
		end
		if (cmd.mul) begin
			prod_a_q <= SUM_W'($signed({1'b0, pos_op_q})) * SUM_W'(prev_op_q);
			prod_b_q <= SUM_W'($signed({1'b0, rest_op_q})) * SUM_W'(cur_q);
		end
		if (cmd.sum) begin
			sum_q <= prod_a_q + prod_b_q;
		end
	end

	assign sum_neg = -sum_q;
	assign trial   = {rem_q, dvd_q[MAG_W-1]};
	assign ge      = trial >= {1'b0, k_q};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			neg_q <= sum_q[SUM_W-1];
			dvd_q <= sum_q[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_q[MAG_W-1:0];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? K_W'(trial - {1'b0, k_q}) : trial[K_W-1:0];
			dvd_q <= {dvd_q[MAG_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_init) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign quot  = dvd_q[VAL_W-1:0];
	assign q_val = pos_zero_q ? cur_q : (neg_q ? -quot : quot);

	// Output register.
	assign out_free = !raised_valid || raised_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raised_valid <= 1'b0;
		end else if (cmd.emit_q || cmd.emit_end) begin
			raised_valid <= 1'b1;
		end else if (raised_ready) begin
			raised_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_q) begin
			raised_value <= q_val;
			row_end      <= 1'b0;
		end else if (cmd.emit_end) begin
			raised_value <= cur_q;
			row_end      <= 1'b1;
		end
	end

	always_comb begin
		sts.pos_zero = (pos_eff == '0);
		sts.row_last = last_q;
		sts.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
		sts.out_free = out_free;
	end

endmodule

### sv/bde_checker.sv
// ----------------------------------------------------------------------------
// bde_checker: port-level assertions for the degree elevation core
// Watches the handshakes and the register read path from the outside.
// ----------------------------------------------------------------------------
module bde_checker import bde_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    psel,
	input logic                    pwrite,
	input logic [DATA_W-1:0]       prdata,
	input logic                    pready,
	input logic                    point_valid,
	input logic                    point_ready,
	input logic                    raised_valid,
	input logic                    raised_ready,
	input logic signed [VAL_W-1:0] raised_value,
	input logic                    row_end
);

	// A stalled result holds its value and flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		raised_valid && !raised_ready |=>
			raised_valid && $stable(raised_value) && $stable(row_end))
		else $error("raised result changed while stalled");

	// One request at a time: the core is busy the cycle after a request.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_ready |=> !point_ready)
		else $error("request taken on consecutive cycles");

	// The length register reads back within its nine bits.
	a_read_width: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite |-> prdata[DATA_W-1:K_W] == '0)
		else $error("register read has bits above the length field");

	// Once a row end is taken, the next cycle cannot show another row end:
	// a new row needs a fresh request first.
	a_end_then_request: assert property (@(posedge clk) disable iff (!arst_n)
		raised_valid && raised_ready && row_end |=>
			!(raised_valid && row_end))
		else $error("row end repeated without a new request");

	// The write side of the port is always ready.
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready dropped");

endmodule

bind bezier_degree_elevation_core bde_checker u_bde_checker (.*);

### tb/bezier_degree_elevation_core_tb.sv
// ----------------------------------------------------------------------------
// bezier_degree_elevation_core_tb: self-checking bench for degree elevation
// Streams control coordinates through the core under several row lengths,
// predicts every raised coordinate and row_end flag with an in-bench model of
// the weighted average, and compares each result in order. Both handshakes
// idle at random, and row_points is rewritten between phases over APB.
// ----------------------------------------------------------------------------
module bezier_degree_elevation_core_tb;
	import bde_pkg::*;

	localparam int MAX_POINTS = 256;
	localparam int RANDOM_POINTS = 700;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             last;
	} raised_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    point_valid;
	logic                    point_ready;
	logic signed [VAL_W-1:0] point_value;
	logic                    raised_valid;
	logic                    raised_ready = 1'b0;
	logic signed [VAL_W-1:0] raised_value;
	logic                    row_end;

	// Prediction state: programmed length, position in row, last input
	logic [K_W-1:0]   row_len;
	int unsigned      row_pos;
	logic [VAL_W-1:0] prev_point;

	raised_t pending_raised[$];
	int      mismatches;
	int      points_sent;
	int      results_seen;
	int      length_writes;
	int      random_sent;
	bit      steady;  // suppress idling on both sides

	bezier_degree_elevation_core #(
		.MAX_POINTS(MAX_POINTS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point_value (point_value),
		.raised_valid(raised_valid),
		.raised_ready(raised_ready),
		.raised_value(raised_value),
		.row_end     (row_end)
	);

	always #5 clk = ~clk;

	// Predict the raised coordinates caused by one accepted request and queue them.
	function automatic void elevate_point(input logic [VAL_W-1:0] cur);
		int unsigned k;
		int unsigned pos;
		longint      weighted;
		raised_t     r;
		// Zero length acts as one; long rows clamp to what the position counter holds
		k = (row_len == 0) ? 1 : row_len;
		if (k > MAX_POINTS) k = MAX_POINTS;
		if (k > 256) k = 256;
		// A shortened length that the position already passed opens a new row
		pos = (row_pos >= k) ? 0 : row_pos;
		if (pos == 0) begin
			r.value = cur;
		end else begin
			weighted = longint'(pos) * longint'($signed(prev_point))
				+ longint'(k - pos) * longint'($signed(cur));
			// SystemVerilog division truncates toward zero
			r.value = VAL_W'(weighted / longint'(k));
		end
		r.last = 1'b0;
		pending_raised.push_back(r);
		if (pos + 1 >= k) begin
			// Close the row: Q(k) repeats the last input with row_end set
			r.value = cur;
			r.last  = 1'b1;
			pending_raised.push_back(r);
			row_pos = 0;
		end else begin
			row_pos = pos + 1;
		end
		prev_point = cur;
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: pick_value = 32'h7FFF_FFFF;
			1: pick_value = 32'h8000_0000;
			2: pick_value = VAL_W'($signed($urandom_range(0, 2000)) - 1000);
			3: pick_value = {16'($urandom_range(0, 65535)), 16'h0000};
			default: pick_value = $urandom;
		endcase
	endfunction

	// Present one request and hold it until accepted; valid stays up afterwards
	// so that a following call can continue back to back.
	task automatic send_point(input logic [VAL_W-1:0] v);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 10) begin
			point_valid <= 1'b0;
			@(negedge clk);
		end
		point_valid <= 1'b1;
		point_value <= v;
		@(posedge clk);
		while (!point_ready) @(posedge clk);
		elevate_point(v);
		points_sent++;
	endtask

	// Drop valid and hold off until every predicted result has come out.
	task automatic wait_for_results();
		@(negedge clk);
		point_valid <= 1'b0;
		while (pending_raised.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write of row_points; only called with the core idle.
	task automatic write_row_points(input logic [DATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({REG_ROW_POINTS, 2'b00});
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		row_len = data[K_W-1:0];
		length_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Reset length k = 2: extreme values, two full rows.
	task automatic test_default_length();
		send_point(32'h7FFF_FFFF);
		send_point(32'h8000_0000);
		send_point(32'h8000_0000);
		send_point(32'h7FFF_FFFF);
		wait_for_results();
	endtask

	// One-point rows, both programmed as 1 and as 0.
	task automatic test_single_point_rows();
		write_row_points(32'd1);
		send_point(32'hFFFF_FFFF);
		send_point(32'h0001_0000);
		wait_for_results();
		write_row_points(32'd0);
		send_point(32'h8000_0000);
		send_point(32'h7FFF_FFFF);
		wait_for_results();
	endtask

	// Largest weighted sums of both signs, with and without remainder.
	task automatic test_extreme_weights();
		write_row_points(32'd3);
		send_point(32'h7FFF_FFFF);
		send_point(32'h8000_0000);
		send_point(32'h7FFF_FFFF);
		wait_for_results();
		write_row_points(32'd4);
		send_point(32'hFFFF_FFFF);
		send_point(32'h0000_0001);
		send_point(32'h8000_0000);
		send_point(32'h7FFF_FFFF);
		wait_for_results();
	endtask

	// Shrink the length below the current position: the next request opens a row.
	task automatic test_length_change();
		write_row_points(32'd5);
		send_point(32'h0000_0007);
		send_point(32'hFFFF_FFF9);
		send_point(32'h0003_8000);
		wait_for_results();
		write_row_points(32'd2);
		send_point(32'h1234_5678);
		send_point(32'hEDCB_A988);
		send_point(32'h0000_0000);
		wait_for_results();
	endtask

	// Out-of-range length clamps to 256; run past a full row with no idling.
	task automatic test_saturated_row();
		write_row_points(32'hFFFF_FFFF);
		steady = 1'b1;
		repeat (MAX_POINTS + 1) begin
			send_point(pick_value());
			random_sent++;
		end
		wait_for_results();
		steady = 1'b0;
	endtask

	// Random phases: mostly short rows, now and then long or clamped lengths,
	// with upper data bits set to prove the write is masked to nine bits.
	task automatic test_random_rows();
		int unsigned k;
		int          n;
		while (random_sent < RANDOM_POINTS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: k = $urandom_range(1, 8);
				6, 7:             k = $urandom_range(9, 40);
				8:                k = $urandom_range(0, 511);
				default:          k = 256;
			endcase
			write_row_points({23'($urandom_range(0, 8388607)), k[K_W-1:0]});
			n = $urandom_range(5, 40);
			repeat (n) begin
				send_point(pick_value());
				random_sent++;
			end
			wait_for_results();
		end
	endtask

	// Receiver side: idle about one cycle in ten unless held steady.
	always @(negedge clk) begin
		raised_ready <= steady || ($urandom_range(0, 99) >= 10);
	end

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		raised_t e;
		if (arst_n && raised_valid && raised_ready) begin
			results_seen++;
			if (pending_raised.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h row_end %b", raised_value, row_end);
			end else begin
				e = pending_raised.pop_front();
				if (raised_value !== e.value || row_end !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value %h row_end %b, got value %h row_end %b",
							e.value, e.last, raised_value, row_end);
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		point_valid  = 1'b0;
		point_value  = '0;
		row_len      = ROW_POINTS_RESET;
		row_pos      = 0;
		prev_point   = '0;
		steady       = 1'b0;
		mismatches   = 0;
		points_sent  = 0;
		results_seen = 0;
		length_writes = 0;
		random_sent  = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_default_length();
		test_single_point_rows();
		test_extreme_weights();
		test_length_change();
		test_saturated_row();
		test_random_rows();

		// Drain, then give the core time to show any stray result
		wait_for_results();
		repeat (60) @(negedge clk);
		$display("sent %0d points over %0d row length settings, checked %0d raised values",
			points_sent, length_writes, results_seen);
		$display("lengths 0, 1, 2..40, 256 and clamped above 256; %0d mismatches", mismatches);
		if (mismatches == 0 && pending_raised.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog well above the slowest legal run
	initial begin
		#5000000;
		$display("timeout with %0d results outstanding", pending_raised.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
